// File: hw/rtl/bpcf_pkg.sv
// Package for the band plan channel frequency unit.
// Holds the register index codes, mode flag positions, fixed frequencies and shared types.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bpcf_pkg;

    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 27;
    localparam int IDX_W      = 9;
    localparam int FREQ_W     = 32;
    localparam int NUM_W      = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MODE_FLAGS      = 4'd0,
        CFG_START_FREQUENCY = 4'd1,
        CFG_END_FREQUENCY   = 4'd2,
        CFG_CHANNEL_SPACING = 4'd3,
        CFG_REPEATER_OFFSET = 4'd4,
        CFG_BASE_BANK       = 4'd5,
        CFG_MAIN_NUMBERS    = 4'd6,
        CFG_OFFSET_NUMBERS  = 4'd7
    } t_cfg_idx;

    localparam int FLG_ENABLED    = 0;
    localparam int FLG_BANK_OFS   = 1;
    localparam int FLG_BASE_NUM   = 2;
    localparam int FLG_INTERLEAVE = 3;
    localparam int FLG_PRIOR      = 4;
    localparam int FLG_DUPLEX     = 5;
    localparam int FLG_PLUS       = 6;
    localparam int FLG_SIMPLEX_TX = 7;
    localparam int FLG_FIXED_HIGH = 8;

    localparam logic [FREQ_W-1:0] FIXED_HIGH_A = 32'd15457000;
    localparam logic [FREQ_W-1:0] FIXED_HIGH_B = 32'd15460000;
    localparam logic [6:0]        KHZ_TO_UNITS = 7'd100;

    localparam logic [IDX_W-1:0] FIXED_IDX_A = 9'd4;
    localparam logic [IDX_W-1:0] FIXED_IDX_B = 9'd5;

    typedef struct packed {
        logic [9:0]  mode_flags;
        logic [26:0] start_frequency;
        logic [26:0] end_frequency;
        logic [15:0] channel_spacing;
        logic [15:0] repeater_offset;
        logic [7:0]  base_bank_channels;
        logic [15:0] main_number_starts;
        logic [15:0] offset_number_starts;
    } t_plan;

    typedef struct packed {
        logic              valid_res;
        logic [FREQ_W-1:0] rx_frequency;
        logic [FREQ_W-1:0] tx_frequency;
        logic [NUM_W-1:0]  display_number;
    } t_result;

endpackage

`default_nettype wire

// File: hw/rtl/bpcf_map.sv
// Combinational channel mapping from a channel index to frequencies and number.
// Depends on bpcf_pkg for the plan and result types and the flag positions.
`timescale 1ns / 1ps
`default_nettype none

module bpcf_map (
    input  var bpcf_pkg::t_plan     i_plan,
    input  wire [8:0]               i_idx,
    output var bpcf_pkg::t_result   o_res
);

    logic [9:0]  flg;
    logic [7:0]  total;
    logic [8:0]  half_sum;
    logic [7:0]  half;
    logic [8:0]  total2;
    logic        plan_ok;
    logic        ofs_hit;
    logic [8:0]  idx_r;
    logic        range_ok;
    logic        upper;
    logic [8:0]  mult_full;
    logic [7:0]  mult;
    logic [14:0] ilv;
    logic [23:0] prod;
    logic [31:0] start_ext;
    logic [31:0] rx_base;
    logic [22:0] shift_amt;
    logic [31:0] shifted;
    logic        duplex_tx;
    logic        simplex;
    logic [31:0] rx;
    logic [31:0] tx;
    logic [7:0]  num_base;
    logic [15:0] num;

    always_comb begin
        flg       = i_plan.mode_flags;
        total     = i_plan.base_bank_channels;
        half_sum  = {1'b0, total} + 9'd1;
        half      = half_sum[8:1];
        total2    = {total, 1'b0};
        plan_ok   = flg[bpcf_pkg::FLG_ENABLED]
                    && (i_plan.end_frequency > i_plan.start_frequency)
                    && (i_plan.channel_spacing != 16'd0) && (i_idx != 9'd0);
        ofs_hit   = flg[bpcf_pkg::FLG_BANK_OFS] && (i_idx > {1'b0, total})
                    && (i_idx <= total2);
        idx_r     = ofs_hit ? (i_idx - {1'b0, total}) : i_idx;
        range_ok  = (idx_r <= {1'b0, total});
        upper     = flg[bpcf_pkg::FLG_INTERLEAVE] && (idx_r > {1'b0, half});
        mult_full = idx_r - 9'd1 - (upper ? {1'b0, half} : 9'd0);
        mult      = mult_full[7:0];
        ilv       = upper ? i_plan.channel_spacing[15:1] : 15'd0;
        prod      = {16'd0, mult} * {8'd0, i_plan.channel_spacing};
        start_ext = {5'd0, i_plan.start_frequency};
        if (flg[bpcf_pkg::FLG_PRIOR]) begin
            rx_base = start_ext - {17'd0, ilv} + {8'd0, prod};
        end else begin
            rx_base = start_ext + {17'd0, ilv} + {8'd0, prod};
        end
        shift_amt = {7'd0, i_plan.repeater_offset} * {16'd0, bpcf_pkg::KHZ_TO_UNITS};
        shifted   = flg[bpcf_pkg::FLG_PLUS] ? (rx_base + {9'd0, shift_amt})
                                            : (rx_base - {9'd0, shift_amt});
        duplex_tx = flg[bpcf_pkg::FLG_DUPLEX] && (i_plan.repeater_offset != 16'd0)
                    && !ofs_hit;
        simplex   = flg[bpcf_pkg::FLG_SIMPLEX_TX] || ofs_hit;
        rx = rx_base;
        tx = rx_base;
        if (duplex_tx) begin
            tx = shifted;
        end else if (simplex) begin
            rx = shifted;
            tx = shifted;
        end
        if (flg[bpcf_pkg::FLG_FIXED_HIGH]) begin
            if (idx_r == bpcf_pkg::FIXED_IDX_A) begin
                rx = bpcf_pkg::FIXED_HIGH_A;
                tx = bpcf_pkg::FIXED_HIGH_A;
            end else if (idx_r == bpcf_pkg::FIXED_IDX_B) begin
                rx = bpcf_pkg::FIXED_HIGH_B;
                tx = bpcf_pkg::FIXED_HIGH_B;
            end
        end
        if (upper) begin
            num_base = ofs_hit ? i_plan.offset_number_starts[15:8]
                               : i_plan.main_number_starts[15:8];
        end else begin
            num_base = ofs_hit ? i_plan.offset_number_starts[7:0]
                               : i_plan.main_number_starts[7:0];
        end
        if (flg[bpcf_pkg::FLG_BASE_NUM]) begin
            num = {7'd0, idx_r} - (upper ? {8'd0, half} : 16'd0)
                  + {8'd0, num_base} - 16'd1;
        end else begin
            num = {7'd0, idx_r};
        end
        if (plan_ok && range_ok) begin
            o_res.valid_res      = 1'b1;
            o_res.rx_frequency   = rx;
            o_res.tx_frequency   = tx;
            o_res.display_number = num;
        end else begin
            o_res = '0;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/band_plan_channel_frequency_unit.sv
// Top level of the band plan channel frequency unit: plan registers, input and result stages.
// Depends on bpcf_pkg and bpcf_map.
//
//   Channel   Direction  Handshake                   Payload
//   config    in         i_cfg_valid / o_cfg_ready   i_cfg_index, i_cfg_data
//   index     in         i_in_valid / o_in_ready     i_channel_index
//   result    out        o_out_valid / i_out_ready   o_valid_res, o_rx_frequency,
//                                                    o_tx_frequency, o_display_number
//
// Each beat is captured in an input register and its result is loaded into the result register
// as soon as that register is empty or being read out.
// One index is accepted every cycle while the result stage is not stalled; the multiplies in the mapping set the path.
// A stalled result holds its register while the input stage keeps one more beat.
// Reset clears all plan registers and both stage valid flags; there is no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module band_plan_channel_frequency_unit (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire [3:0]   i_cfg_index,
    input  wire [26:0]  i_cfg_data,
    input  wire         i_in_valid,
    output logic        o_in_ready,
    input  wire [8:0]   i_channel_index,
    output logic        o_out_valid,
    input  wire         i_out_ready,
    output logic        o_valid_res,
    output logic [31:0] o_rx_frequency,
    output logic [31:0] o_tx_frequency,
    output logic [15:0] o_display_number
);

    bpcf_pkg::t_plan   r_plan;
    logic              r_in_vld;
    logic [8:0]        r_idx;
    logic              r_out_vld;
    bpcf_pkg::t_result r_res;
    bpcf_pkg::t_result n_res;
    logic              out_load;

    assign o_cfg_ready = 1'b1;
    assign out_load    = !r_out_vld || i_out_ready;
    assign o_in_ready  = !r_in_vld || out_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_plan <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                bpcf_pkg::CFG_MODE_FLAGS:      r_plan.mode_flags <= i_cfg_data[9:0];
                bpcf_pkg::CFG_START_FREQUENCY: r_plan.start_frequency <= i_cfg_data;
                bpcf_pkg::CFG_END_FREQUENCY:   r_plan.end_frequency <= i_cfg_data;
                bpcf_pkg::CFG_CHANNEL_SPACING: r_plan.channel_spacing <= i_cfg_data[15:0];
                bpcf_pkg::CFG_REPEATER_OFFSET: r_plan.repeater_offset <= i_cfg_data[15:0];
                bpcf_pkg::CFG_BASE_BANK:       r_plan.base_bank_channels <= i_cfg_data[7:0];
                bpcf_pkg::CFG_MAIN_NUMBERS:    r_plan.main_number_starts <= i_cfg_data[15:0];
                bpcf_pkg::CFG_OFFSET_NUMBERS:  r_plan.offset_number_starts <= i_cfg_data[15:0];
                default: begin
                end
            endcase
        end
    end

    bpcf_map u_map (
        .i_plan (r_plan),
        .i_idx  (r_idx),
        .o_res  (n_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_vld <= i_in_valid;
            end
            if (out_load) begin
                r_out_vld <= r_in_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_idx <= i_channel_index;
        end
        if (out_load && r_in_vld) begin
            r_res <= n_res;
        end
    end

    assign o_out_valid      = r_out_vld;
    assign o_valid_res      = r_res.valid_res;
    assign o_rx_frequency   = r_res.rx_frequency;
    assign o_tx_frequency   = r_res.tx_frequency;
    assign o_display_number = r_res.display_number;

    a_in_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_vld && !out_load) |=> (r_in_vld && $stable(r_idx)))
        else $error("Input stage dropped or changed a waiting beat.");

    a_ready_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (r_in_vld && r_out_vld))
        else $error("Input stage refused a beat while it had room.");

    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_valid_res) |->
        (o_rx_frequency == 32'd0 && o_tx_frequency == 32'd0 && o_display_number == 16'd0))
        else $error("Invalid result carries nonzero fields.");

    a_valid_enabled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_valid_res) |->
        (r_plan.mode_flags[bpcf_pkg::FLG_ENABLED] && r_plan.channel_spacing != 16'd0))
        else $error("Valid result from a disabled plan.");

endmodule

`default_nettype wire

// File: test/tb_top.sv
// Testbench for band_plan_channel_frequency_unit: directed and random channel lookups are
// checked against a built-in band plan mapper, under random idling and stalls on the index and result channels.
// Depends on bpcf_pkg and the unit's RTL.
`timescale 1ns / 1ps

module tb_top;
    import bpcf_pkg::*;

    localparam int STALL_LIMIT     = 1000;
    localparam int SETTLE_CYCLES   = 8;
    localparam int MAX_IDLE        = 18;
    localparam int RANDOM_PHASES   = 26;
    localparam int ITEMS_PER_PHASE = 48;
    localparam int PRINT_LIMIT     = 50;

    localparam logic [9:0] M_EN       = 10'd1 << FLG_ENABLED;
    localparam logic [9:0] M_BANK_OFS = 10'd1 << FLG_BANK_OFS;
    localparam logic [9:0] M_BASE_NUM = 10'd1 << FLG_BASE_NUM;
    localparam logic [9:0] M_ILV      = 10'd1 << FLG_INTERLEAVE;
    localparam logic [9:0] M_PRIOR    = 10'd1 << FLG_PRIOR;
    localparam logic [9:0] M_DUPLEX   = 10'd1 << FLG_DUPLEX;
    localparam logic [9:0] M_PLUS     = 10'd1 << FLG_PLUS;
    localparam logic [9:0] M_SIMPLEX  = 10'd1 << FLG_SIMPLEX_TX;
    localparam logic [9:0] M_FIXED    = 10'd1 << FLG_FIXED_HIGH;

    typedef struct {
        logic [8:0] chan;
        t_result    res;
    } pending_t;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [3:0]  i_cfg_index;
    logic [26:0] i_cfg_data;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [8:0]  i_channel_index;
    logic        o_out_valid;
    logic        i_out_ready;
    logic        o_valid_res;
    logic [31:0] o_rx_frequency;
    logic [31:0] o_tx_frequency;
    logic [15:0] o_display_number;

    t_plan    plan_q;
    pending_t pending_q[$];
    int       mismatch_count = 0;
    int       idle_cycles = 0;
    int       sink_hold = 0;
    bit       src_idle = 1'b1;
    bit       sink_idle = 1'b1;

    band_plan_channel_frequency_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_channel_index (i_channel_index),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_valid_res     (o_valid_res),
        .o_rx_frequency  (o_rx_frequency),
        .o_tx_frequency  (o_tx_frequency),
        .o_display_number(o_display_number)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic t_result map_channel(logic [8:0] chan);
        t_result     r;
        logic [31:0] idx, total, half, mult, ilv, rx, tx, shift, num;
        logic        in_ofs, upper;
        r = '0;
        idx = 32'(chan);
        total = 32'(plan_q.base_bank_channels);
        half = (total + 32'd1) >> 1;
        in_ofs = 1'b0;
        ilv = 32'd0;
        if (!plan_q.mode_flags[FLG_ENABLED] || plan_q.end_frequency <= plan_q.start_frequency
                || plan_q.channel_spacing == 16'd0 || idx == 32'd0)
            return r;
        if (plan_q.mode_flags[FLG_BANK_OFS] && idx > total && idx <= 32'd2 * total) begin
            idx = idx - total;
            in_ofs = 1'b1;
        end
        if (idx > total)
            return r;
        upper = plan_q.mode_flags[FLG_INTERLEAVE] && idx > half;
        mult = idx - 32'd1;
        if (upper) begin
            ilv = 32'(plan_q.channel_spacing >> 1);
            mult = mult - half;
        end
        if (plan_q.mode_flags[FLG_PRIOR])
            rx = 32'(plan_q.start_frequency) - ilv + mult * 32'(plan_q.channel_spacing);
        else
            rx = 32'(plan_q.start_frequency) + ilv + mult * 32'(plan_q.channel_spacing);
        tx = rx;
        shift = 32'(plan_q.repeater_offset) * 32'(KHZ_TO_UNITS);
        if (plan_q.mode_flags[FLG_DUPLEX] && plan_q.repeater_offset != 16'd0 && !in_ofs) begin
            tx = plan_q.mode_flags[FLG_PLUS] ? tx + shift : tx - shift;
        end else if (plan_q.mode_flags[FLG_SIMPLEX_TX] || in_ofs) begin
            tx = plan_q.mode_flags[FLG_PLUS] ? tx + shift : tx - shift;
            rx = tx;
        end
        if (plan_q.mode_flags[FLG_FIXED_HIGH]) begin
            if (idx == 32'(FIXED_IDX_A)) begin
                rx = FIXED_HIGH_A;
                tx = rx;
            end else if (idx == 32'(FIXED_IDX_B)) begin
                rx = FIXED_HIGH_B;
                tx = rx;
            end
        end
        num = idx;
        if (plan_q.mode_flags[FLG_BASE_NUM]) begin
            if (upper)
                num = idx - half - 32'd1 + 32'(in_ofs ? plan_q.offset_number_starts[15:8]
                                                      : plan_q.main_number_starts[15:8]);
            else
                num = idx - 32'd1 + 32'(in_ofs ? plan_q.offset_number_starts[7:0]
                                               : plan_q.main_number_starts[7:0]);
        end
        r.valid_res = 1'b1;
        r.rx_frequency = rx;
        r.tx_frequency = tx;
        r.display_number = num[15:0];
        return r;
    endfunction

    function automatic t_plan make_plan(logic [9:0] flags, logic [26:0] start_f,
                                        logic [26:0] stop_f, logic [15:0] spacing,
                                        logic [15:0] offset, logic [7:0] bank,
                                        logic [15:0] main_nums, logic [15:0] ofs_nums);
        t_plan p;
        p.mode_flags = flags;
        p.start_frequency = start_f;
        p.end_frequency = stop_f;
        p.channel_spacing = spacing;
        p.repeater_offset = offset;
        p.base_bank_channels = bank;
        p.main_number_starts = main_nums;
        p.offset_number_starts = ofs_nums;
        return p;
    endfunction

    function automatic t_plan random_plan();
        t_plan p;
        p.mode_flags = 10'($urandom_range(0, 1023));
        if ($urandom_range(0, 9) != 0)
            p.mode_flags[FLG_ENABLED] = 1'b1;
        if ($urandom_range(0, 7) == 0)
            p.start_frequency = 27'($urandom());
        else
            p.start_frequency = 27'($urandom_range(0, 99999999));
        case ($urandom_range(0, 11))
            0: p.end_frequency = 27'($urandom());
            1: p.end_frequency = p.start_frequency;
            default: p.end_frequency = p.start_frequency + 27'($urandom_range(1, 4000000));
        endcase
        case ($urandom_range(0, 11))
            0: p.channel_spacing = 16'd0;
            1, 2: p.channel_spacing = 16'($urandom_range(1, 4));
            default: p.channel_spacing = 16'($urandom_range(1, 65535));
        endcase
        p.repeater_offset = ($urandom_range(0, 5) == 0) ? 16'd0 : 16'($urandom());
        if ($urandom_range(0, 3) == 0)
            p.base_bank_channels = 8'($urandom_range(0, 255));
        else
            p.base_bank_channels = 8'($urandom_range(1, 40));
        p.main_number_starts = 16'($urandom());
        p.offset_number_starts = 16'($urandom());
        return p;
    endfunction

    function automatic logic [8:0] pick_index();
        int total, span;
        total = plan_q.base_bank_channels;
        span = plan_q.mode_flags[FLG_BANK_OFS] ? 2 * total : total;
        case ($urandom_range(0, 9))
            0, 1: return 9'($urandom_range(0, 511));
            2: return 9'(span + 1);
            3: return 9'((total + 1) / 2 + $urandom_range(0, 1));
            4: return 9'($urandom_range(4, 5));
            default: return 9'($urandom_range(1, (span > 0) ? span : 1));
        endcase
    endfunction

    function automatic int draw_idle(bit enabled);
        return enabled ? $urandom_range(0, MAX_IDLE) : 0;
    endfunction

    task automatic report_mismatch(string what, logic [8:0] chan, logic [31:0] want,
                                   logic [31:0] got);
        mismatch_count++;
        if (mismatch_count <= PRINT_LIMIT)
            $display("MISMATCH %s at channel %0d: expected 0x%0h, got 0x%0h",
                     what, chan, want, got);
    endtask

    task automatic write_plan_reg(t_cfg_idx idx, logic [26:0] data);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_MODE_FLAGS:      plan_q.mode_flags = data[9:0];
            CFG_START_FREQUENCY: plan_q.start_frequency = data;
            CFG_END_FREQUENCY:   plan_q.end_frequency = data;
            CFG_CHANNEL_SPACING: plan_q.channel_spacing = data[15:0];
            CFG_REPEATER_OFFSET: plan_q.repeater_offset = data[15:0];
            CFG_BASE_BANK:       plan_q.base_bank_channels = data[7:0];
            CFG_MAIN_NUMBERS:    plan_q.main_number_starts = data[15:0];
            CFG_OFFSET_NUMBERS:  plan_q.offset_number_starts = data[15:0];
            default: ;
        endcase
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        while (pending_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Unused upper data bits carry random junk, which the unit must ignore.
    task automatic load_plan(t_plan p);
        wait_drained();
        write_plan_reg(CFG_MODE_FLAGS, {17'($urandom()), p.mode_flags});
        write_plan_reg(CFG_START_FREQUENCY, p.start_frequency);
        write_plan_reg(CFG_END_FREQUENCY, p.end_frequency);
        write_plan_reg(CFG_CHANNEL_SPACING, {11'($urandom()), p.channel_spacing});
        write_plan_reg(CFG_REPEATER_OFFSET, {11'($urandom()), p.repeater_offset});
        write_plan_reg(CFG_BASE_BANK, {19'($urandom()), p.base_bank_channels});
        write_plan_reg(CFG_MAIN_NUMBERS, {11'($urandom()), p.main_number_starts});
        write_plan_reg(CFG_OFFSET_NUMBERS, {11'($urandom()), p.offset_number_starts});
        i_cfg_valid = 1'b0;
    endtask

    task automatic send_channel(logic [8:0] chan);
        int       gap;
        pending_t entry;
        gap = draw_idle(src_idle);
        if (gap > 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_channel_index = chan;
        do @(posedge i_clk); while (!o_in_ready);
        entry.chan = chan;
        entry.res = map_channel(chan);
        pending_q.push_back(entry);
        @(negedge i_clk);
        i_in_valid = 1'b0;
    endtask

    task automatic send_list(logic [8:0] chans[$]);
        foreach (chans[k])
            send_channel(chans[k]);
    endtask

    task automatic run_items(int count);
        repeat (count) send_channel(pick_index());
    endtask

    task automatic test_reset_state();
        send_list('{9'd1, 9'd511});
    endtask

    task automatic test_bank_and_fixed_channels();
        load_plan(make_plan(M_EN | M_BANK_OFS | M_BASE_NUM | M_DUPLEX | M_FIXED,
                            27'd14400000, 27'd14800000, 16'd1250, 16'd600, 8'd8,
                            16'h1401, 16'h2A50));
        send_list('{9'd0, 9'd1, 9'd4, 9'd5, 9'd8, 9'd9, 9'd16, 9'd17, 9'd511});
    endtask

    task automatic test_interleave_extremes();
        load_plan(make_plan(M_EN | M_ILV | M_PRIOR | M_SIMPLEX | M_PLUS | M_BASE_NUM,
                            27'h7FFFFFE, 27'h7FFFFFF, 16'hFFFF, 16'hFFFF, 8'd255,
                            16'hFFFF, 16'h0000));
        send_list('{9'd1, 9'd128, 9'd129, 9'd255, 9'd256});
        load_plan(make_plan(M_EN | M_BANK_OFS | M_ILV | M_BASE_NUM | M_DUPLEX,
                            27'd43000000, 27'd44000000, 16'd2500, 16'd5000, 8'd6,
                            16'h0A01, 16'h3020));
        send_list('{9'd3, 9'd4, 9'd10, 9'd12, 9'd13});
    endtask

    task automatic test_invalid_plans();
        load_plan(make_plan(M_BANK_OFS | M_DUPLEX, 27'd100, 27'd200, 16'd10, 16'd1, 8'd10,
                            16'h0101, 16'h0101));
        send_channel(9'd1);
        load_plan(make_plan(M_EN, 27'd5000, 27'd5000, 16'd10, 16'd1, 8'd10,
                            16'h0101, 16'h0101));
        send_channel(9'd1);
        load_plan(make_plan(M_EN, 27'd5000, 27'd9000, 16'd0, 16'd1, 8'd10,
                            16'h0101, 16'h0101));
        send_channel(9'd1);
    endtask

    task automatic test_backpressure();
        load_plan(make_plan(M_EN | M_BANK_OFS | M_DUPLEX | M_PLUS, 27'd14500000,
                            27'd14600000, 16'd1250, 16'd600, 8'd16, 16'h0101, 16'h0101));
        src_idle = 1'b0;
        sink_idle = 1'b1;
        sink_hold = 120;
        run_items(30);
        src_idle = 1'b1;
    endtask

    task automatic test_drain_pause();
        load_plan(random_plan());
        run_items(15);
        wait_drained();
        run_items(15);
    endtask

    task automatic test_random_plans();
        t_plan p;
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            if (ph == 0)
                p = make_plan(10'h3FF, 27'd0, 27'h7FFFFFF, 16'hFFFF, 16'hFFFF, 8'd255,
                              16'hFFFF, 16'hFFFF);
            else if (ph == 1)
                p = make_plan(M_EN, 27'd0, 27'd1, 16'd1, 16'd0, 8'd1, 16'h0000, 16'h0000);
            else
                p = random_plan();
            load_plan(p);
            src_idle = ($urandom_range(0, 3) != 0);
            sink_idle = ($urandom_range(0, 3) != 0);
            run_items(ITEMS_PER_PHASE);
        end
    endtask

    initial begin : result_sink
        int stall;
        i_out_ready = 1'b0;
        wait (i_rst_n);
        forever begin
            @(negedge i_clk);
            if (sink_hold > 0) begin
                i_out_ready = 1'b0;
                repeat (sink_hold) @(negedge i_clk);
                sink_hold = 0;
            end
            stall = draw_idle(sink_idle);
            if (stall > 0) begin
                i_out_ready = 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            i_out_ready = 1'b1;
            do @(posedge i_clk); while (!o_out_valid && sink_hold == 0);
        end
    end

    always @(posedge i_clk) begin : result_check
        pending_t want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_q.size() == 0) begin
                report_mismatch("result beat with nothing pending", 9'd0, 32'd0,
                                o_rx_frequency);
            end else begin
                want = pending_q.pop_front();
                if (o_valid_res !== want.res.valid_res)
                    report_mismatch("valid_res", want.chan, 32'(want.res.valid_res),
                                    32'(o_valid_res));
                if (o_rx_frequency !== want.res.rx_frequency)
                    report_mismatch("rx_frequency", want.chan, want.res.rx_frequency,
                                    o_rx_frequency);
                if (o_tx_frequency !== want.res.tx_frequency)
                    report_mismatch("tx_frequency", want.chan, want.res.tx_frequency,
                                    o_tx_frequency);
                if (o_display_number !== want.res.display_number)
                    report_mismatch("display_number", want.chan,
                                    32'(want.res.display_number), 32'(o_display_number));
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_cfg_valid && o_cfg_ready) || (i_in_valid && o_in_ready)
                || (o_out_valid && i_out_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("Timeout: no beat accepted for %0d cycles", STALL_LIMIT);
            $display("RESULT: ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : main_seq
        i_rst_n = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = 4'd0;
        i_cfg_data = 27'd0;
        i_in_valid = 1'b0;
        i_channel_index = 9'd0;
        plan_q = '0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reset_state();
        test_bank_and_fixed_channels();
        test_interleave_extremes();
        test_invalid_plans();
        test_backpressure();
        test_drain_pause();
        test_random_plans();

        while (pending_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
